// File: hw/rtl/usart_baud_value_calculator_macros.svh
// Assertion macros for the baud value calculator.
// Each macro expects clk and rst in scope at the point of use.
`ifndef USART_BAUD_VALUE_CALCULATOR_MACROS_SVH
`define USART_BAUD_VALUE_CALCULATOR_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define UBVC_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubvc: implication check failed");

// cons must hold after ante, delayed by the argument n
`define UBVC_ASSERT_AFTER(name, n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("ubvc: latency check failed");

`else

`define UBVC_ASSERT_IMPLIES(name, ante, cons)
`define UBVC_ASSERT_AFTER(name, n, ante, cons)

`endif

`endif

// File: hw/rtl/ubvc_pkg.sv
`default_nettype none

package ubvc_pkg;

  localparam int BAUD_W     = 32;
  localparam int CLK_W      = 32;
  localparam int SPB_W      = 8;
  localparam int PROD_W     = BAUD_W + SPB_W;
  localparam int VALUE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // numerator is the low word of the product shifted up by a full word
  localparam int DIV_STEPS  = 2 * CLK_W;

  localparam int STEPS_PER_STAGE_DEF = 4;

  localparam logic [CLK_W-1:0] REF_CLOCK_RESET = CLK_W'(48000000);
  localparam logic [SPB_W-1:0] SAMPLES_RESET   = SPB_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_CLOCK = 1'b0,
    REG_SAMPLES   = 1'b1
  } cfg_reg_t;

  // one restoring-division slot in the pipeline
  typedef struct packed {
    logic [CLK_W-1:0] rem;   // partial remainder
    logic [CLK_W-1:0] num;   // numerator bits still to shift in, MSB first
    logic [CLK_W-1:0] quo;   // low word of the quotient so far
    logic             flag;  // product exceeds the clock
  } div_t;

  // One restoring step. A zero divisor sets every quotient bit.
  function automatic div_t div_step(input div_t s, input logic [CLK_W-1:0] d);
    logic [CLK_W:0]   shifted;
    logic [CLK_W+1:0] diff;
    div_t             r;
    shifted = {s.rem, s.num[CLK_W-1]};
    diff    = {1'b0, shifted} - {2'b00, d};
    r       = s;
    r.num   = {s.num[CLK_W-2:0], 1'b0};
    if (!diff[CLK_W+1]) begin
      r.rem = diff[CLK_W-1:0];
      r.quo = {s.quo[CLK_W-2:0], 1'b1};
    end else begin
      r.rem = shifted[CLK_W-1:0];
      r.quo = {s.quo[CLK_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/usart_baud_value_calculator.sv
// Channel   Direction  Handshake              Payload
// request   in         start & !busy          baud_rate[31:0]
// result    out        done (one-cycle pulse) baud_value[15:0], rate_too_high
// config    in         cfg_we                 cfg_index, cfg_data[31:0]
//
// One request enters per clock outside reset; a result passes the multiply
// stage, the 64-step restoring divider spread over NUM_STAGES register
// stages (four division steps per stage by default), and the output register.
// busy is high only while rst is asserted; reset clears all valid bits.
// The receiver cannot stall, so there is no back-pressure anywhere inside.
`default_nettype none
`include "usart_baud_value_calculator_macros.svh"

module usart_baud_value_calculator
  import ubvc_pkg::*;
#(
  parameter int STEPS_PER_STAGE = STEPS_PER_STAGE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [BAUD_W-1:0]     baud_rate,
  // result side
  output logic                       done,
  output logic [VALUE_W-1:0]         baud_value,
  output logic                       rate_too_high,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_STAGES = DIV_STEPS / STEPS_PER_STAGE;
  localparam int LATENCY    = NUM_STAGES + 2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CLK_W-1:0] ref_clock_hz;
  logic [SPB_W-1:0] samples_per_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz    <= REF_CLOCK_RESET;
      samples_per_bit <= SAMPLES_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_REF_CLOCK: ref_clock_hz    <= cfg_data[CLK_W-1:0];
        REG_SAMPLES:   samples_per_bit <= cfg_data[SPB_W-1:0];
        default: ;
      endcase
    end
  end

  // every request is taken outside reset
  assign busy = rst;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------------
  // Multiply stage: full 40-bit product of samples and baud rate
  // ---------------------------------------------------------------------
  logic              m_valid;
  logic [PROD_W-1:0] m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= accept;
    end
    m_prod <= PROD_W'(samples_per_bit) * PROD_W'(baud_rate);
  end

  // Only the low word of the product enters the numerator; the wrap flag
  // looks at the full product.
  div_t div_in;
  always_comb begin
    div_in.rem  = '0;
    div_in.num  = m_prod[CLK_W-1:0];
    div_in.quo  = '0;
    div_in.flag = (m_prod > PROD_W'(ref_clock_hz));
  end

  // ---------------------------------------------------------------------
  // Divider pipeline: STEPS_PER_STAGE restoring steps per register stage.
  // The first word of steps only builds the remainder; the second word
  // leaves the low quotient word in quo.
  // ---------------------------------------------------------------------
  div_t stg       [NUM_STAGES];
  logic stg_valid [NUM_STAGES];
  div_t stg_src   [NUM_STAGES];
  logic src_valid [NUM_STAGES];

  for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_stage
    div_t work;

    if (gi == 0) begin : g_first
      assign stg_src[gi]   = div_in;
      assign src_valid[gi] = m_valid;
    end else begin : g_rest
      assign stg_src[gi]   = stg[gi-1];
      assign src_valid[gi] = stg_valid[gi-1];
    end

    always_comb begin
      work = stg_src[gi];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        work = div_step(work, ref_clock_hz);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[gi] <= 1'b0;
      end else begin
        stg_valid[gi] <= src_valid[gi];
      end
      stg[gi] <= work;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: scale = 2^32 - Q, keep bits 31..16
  // ---------------------------------------------------------------------
  logic [CLK_W-1:0] scale_lo;
  assign scale_lo = (~stg[NUM_STAGES-1].quo) + CLK_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stg_valid[NUM_STAGES-1];
    end
    baud_value    <= scale_lo[CLK_W-1:CLK_W-VALUE_W];
    rate_too_high <= stg[NUM_STAGES-1].flag;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // every taken request comes out after the fixed pipeline latency
  `UBVC_ASSERT_AFTER(a_req_to_done, LATENCY, accept, done)
  // no result without a request taken that many cycles earlier
  `UBVC_ASSERT_IMPLIES(a_done_has_req, done, $past(accept, LATENCY))
  // done follows the valid of the last divider stage in the next cycle
  `UBVC_ASSERT_AFTER(a_tail_to_done, 1, stg_valid[NUM_STAGES-1], done)

endmodule

`default_nettype wire

// File: dv/usart_baud_value_calculator_tb.sv
`timescale 1ns / 100ps

// Testbench for the USART arithmetic baud value calculator.
// A directed table covers the corner cases first, then twelve register
// settings each get a burst of random requests. Every request is
// scoreboarded in order against a local predictor of the fixed-point math.
module usart_baud_value_calculator_tb;
  import ubvc_pkg::*;

  // pipe latency with the default four division steps per stage
  localparam int PIPE_LATENCY = 18;
  localparam int PHASES       = 12;
  localparam int PER_PHASE    = 86;
  localparam int NUM_DIRECTED = 21;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               too_high;
  } baud_result_t;

  // one row of the directed table; hand-typed answers only where obvious
  typedef struct packed {
    logic [CLK_W-1:0]   clock_hz;
    logic [SPB_W-1:0]   samples;
    logic [BAUD_W-1:0]  rate;
    logic               typed;
    logic [VALUE_W-1:0] value;
    logic               too_high;
  } directed_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [BAUD_W-1:0]     baud_rate;
  logic                  done;
  logic [VALUE_W-1:0]    baud_value;
  logic                  rate_too_high;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the block's two registers
  logic [CLK_W-1:0] ref_clock_cfg;
  logic [SPB_W-1:0] samples_cfg;

  baud_result_t pending_results[$];
  int           fail_count    = 0;
  int           requests_sent = 0;
  int           results_seen  = 0;
  int           flagged_seen  = 0;
  int           settings_used = 0;
  bit           gaps_on       = 1'b1;

  usart_baud_value_calculator u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .baud_rate     (baud_rate),
    .done          (done),
    .baud_value    (baud_value),
    .rate_too_high (rate_too_high),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // BAUD = bits 31..16 of (2^32 - ((S*f mod 2^32) << 32) / fref).
  // Divide by zero gives all ones, as a restoring divider does.
  // Flag uses the full 40-bit product, not the wrapped one.
  function automatic baud_result_t predict_baud(input logic [BAUD_W-1:0] rate);
    logic [PROD_W-1:0] product;
    logic [63:0]       numer;
    logic [63:0]       quot;
    logic [63:0]       scale;
    baud_result_t      r;
    product = PROD_W'(rate) * PROD_W'(samples_cfg);
    numer   = {product[31:0], 32'd0};
    if (ref_clock_cfg == '0) begin
      quot = '1;
    end else begin
      quot = numer / {32'd0, ref_clock_cfg};
    end
    scale      = 64'h1_0000_0000 - quot;
    r.value    = scale[31:16];
    r.too_high = (product > PROD_W'(ref_clock_cfg));
    return r;
  endfunction

  function automatic logic [CLK_W-1:0] pick_clock();
    if ($urandom_range(1)) begin
      return $urandom();
    end
    return $urandom_range(200_000_000, 1_000_000);
  endfunction

  // Mix of realistic rates, rates right at the overflow knee, tiny values
  // and raw 32-bit noise.
  function automatic logic [BAUD_W-1:0] pick_baud();
    logic [BAUD_W-1:0] knee;
    knee = (samples_cfg == '0) ? '0 : ref_clock_cfg / CLK_W'(samples_cfg);
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(knee);
      3, 4:    return knee - 1 + $urandom_range(2);
      5:       return $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  // Hold start with random gaps, wait for the request to be taken,
  // then queue its answer. start stays high for a back-to-back request.
  task automatic issue_request(input logic [BAUD_W-1:0] rate, input baud_result_t want);
    while (gaps_on && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    baud_rate <= rate;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
    requests_sent++;
  endtask

  // Registers change only with the pipe empty. Upper data bits are noise
  // on the samples write to check that only the low byte lands.
  task automatic apply_settings(input logic [CLK_W-1:0] clock_hz,
                                input logic [CFG_DATA_W-1:0] samples_word);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REF_CLOCK;
    cfg_data  <= clock_hz;
    @(posedge clk);
    cfg_index <= REG_SAMPLES;
    cfg_data  <= samples_word;
    @(posedge clk);
    cfg_we        <= 1'b0;
    ref_clock_cfg = clock_hz;
    samples_cfg   = samples_word[SPB_W-1:0];
    settings_used++;
  endtask

  // Results cannot be stalled: every done pulse is checked at once.
  always @(posedge clk) begin
    baud_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (rate_too_high) flagged_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("[%0t] result with no pending request: baud_value %h rate_too_high %b",
                   $time, baud_value, rate_too_high);
        end
      end else begin
        want = pending_results.pop_front();
        if (baud_value !== want.value || rate_too_high !== want.too_high) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: baud_value exp %h got %h, rate_too_high exp %b got %b",
                     $time, want.value, baud_value, want.too_high, rate_too_high);
          end
        end
      end
    end
  end

  initial begin
    directed_row_t     rows [NUM_DIRECTED];
    baud_result_t      want;
    logic [CLK_W-1:0]  clock_pick;
    logic [31:0]       spb_pick;
    logic [BAUD_W-1:0] rate_pick;

    rows = '{
      // reset settings: zero rate, typical rate
      '{REF_CLOCK_RESET, SAMPLES_RESET, 32'd0,          1'b1, 16'd0, 1'b0},
      '{REF_CLOCK_RESET, SAMPLES_RESET, 32'd115200,     1'b0, 16'd0, 1'b0},
      // product equal to clock, then one past it
      '{REF_CLOCK_RESET, SAMPLES_RESET, 32'd3000000,    1'b1, 16'd0, 1'b0},
      '{REF_CLOCK_RESET, SAMPLES_RESET, 32'd3000001,    1'b0, 16'd0, 1'b0},
      '{REF_CLOCK_RESET, SAMPLES_RESET, 32'hFFFF_FFFF,  1'b0, 16'd0, 1'b0},
      // product wraps to exactly 2^32: numerator zero, flag still set
      '{REF_CLOCK_RESET, SAMPLES_RESET, 32'h1000_0000,  1'b1, 16'd0, 1'b1},
      '{REF_CLOCK_RESET, 8'd8,          32'd9600,       1'b0, 16'd0, 1'b0},
      '{REF_CLOCK_RESET, 8'd3,          32'd115200,     1'b0, 16'd0, 1'b0},
      // zero clock: quotient all ones
      '{32'd0,           8'd16,         32'd1,          1'b1, 16'd0, 1'b1},
      '{32'd0,           8'd16,         32'd0,          1'b1, 16'd0, 1'b0},
      '{32'd0,           8'd255,        32'hFFFF_FFFF,  1'b1, 16'd0, 1'b1},
      // largest clock, zero samples first
      '{32'hFFFF_FFFF,   8'd0,          32'hFFFF_FFFF,  1'b1, 16'd0, 1'b0},
      '{32'hFFFF_FFFF,   8'd1,          32'hFFFF_FFFF,  1'b1, 16'd0, 1'b0},
      '{32'hFFFF_FFFF,   8'd255,        32'hFFFF_FFFF,  1'b0, 16'd0, 1'b0},
      '{32'hFFFF_FFFF,   8'd255,        32'd1,          1'b0, 16'd0, 1'b0},
      // smallest clock, then a 16 MHz clock
      '{32'd1,           8'd1,          32'd1,          1'b1, 16'd0, 1'b0},
      '{32'd1,           8'd1,          32'd2,          1'b0, 16'd0, 1'b0},
      '{32'd1,           8'd255,        32'd0,          1'b1, 16'd0, 1'b0},
      '{32'd1,           8'd255,        32'h8000_0000,  1'b0, 16'd0, 1'b0},
      '{32'd16000000,    8'd16,         32'd1000000,    1'b1, 16'd0, 1'b0},
      '{32'd16000000,    8'd16,         32'd500000,     1'b0, 16'd0, 1'b0}
    };

    rst       <= 1'b1;
    start     <= 1'b0;
    baud_rate <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_REF_CLOCK;
    cfg_data  <= '0;
    ref_clock_cfg = REF_CLOCK_RESET;
    samples_cfg   = SAMPLES_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table; first rows run on the reset values untouched
    foreach (rows[i]) begin
      if (rows[i].clock_hz != ref_clock_cfg || rows[i].samples != samples_cfg) begin
        apply_settings(rows[i].clock_hz, ($urandom() & ~32'hFF) | rows[i].samples);
      end
      if (rows[i].typed) begin
        want.value    = rows[i].value;
        want.too_high = rows[i].too_high;
      end else begin
        want = predict_baud(rows[i].rate);
      end
      issue_request(rows[i].rate, want);
    end

    // random bursts, one register setting per phase, extremes included
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin clock_pick = REF_CLOCK_RESET; spb_pick = SAMPLES_RESET;           end
        1:       begin clock_pick = '0;              spb_pick = $urandom_range(255, 1);  end
        2:       begin clock_pick = 32'd1;           spb_pick = 1;                       end
        3:       begin clock_pick = 32'hFFFF_FFFF;   spb_pick = 255;                     end
        4:       begin clock_pick = pick_clock();    spb_pick = 0;                       end
        5:       begin clock_pick = pick_clock();    spb_pick = 16;                      end
        6:       begin clock_pick = pick_clock();    spb_pick = 8;                       end
        7:       begin clock_pick = pick_clock();    spb_pick = 3;                       end
        default: begin clock_pick = pick_clock();    spb_pick = $urandom_range(255);     end
      endcase
      apply_settings(clock_pick, ($urandom() & ~32'hFF) | spb_pick);
      // phase 5 runs back to back with no gaps at all
      gaps_on = (p != 5);
      for (int n = 0; n < PER_PHASE; n++) begin
        rate_pick = pick_baud();
        issue_request(rate_pick, predict_baud(rate_pick));
      end
    end

    start <= 1'b0;
    for (int k = 0; k < 2000 && pending_results.size() != 0; k++) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    // anything still queued never came back
    fail_count += pending_results.size();

    $display("Sent %0d requests over %0d register settings; %0d results checked, %0d flagged.",
             requests_sent, settings_used, results_seen, flagged_seen);
    if (fail_count == 0) begin
      $display("** usart_baud_value_calculator: PASSED **");
    end else begin
      $display("%0d failures", fail_count);
      $display("** usart_baud_value_calculator: FAILED **");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("** usart_baud_value_calculator: FAILED **");
    $finish;
  end

endmodule
